FILE: hw/rtl/snp_pkg.sv
// Shared types, constants and helper functions for the SNORM 10:10:10 vertex packer.
package snp_pkg;

  localparam int MAN_W      = 24;   // significand with hidden bit
  localparam int EXP_W      = 10;   // signed working exponent, biased
  localparam int LZ_W       = 5;
  localparam int QF_W       = 10;   // one packed field
  localparam int DIV_STAGES = MAN_W + 2;

  localparam int LAT_FRONT = 4;     // input, max, leading-zero count, shift
  localparam int LAT_RCP   = DIV_STAGES + 1;
  localparam int LAT_MUL   = 2;
  localparam int LAT_QUANT = 3;
  localparam int LAT_TOTAL = LAT_FRONT + LAT_RCP + LAT_MUL + LAT_QUANT + 1;

  localparam logic [31:0] ONE_BITS = 32'h3F80_0000;
  localparam logic signed [EXP_W-1:0] EXP_BIAS = 10'sd127;
  localparam logic signed [EXP_W-1:0] EXP_MAX  = 10'sd255;

  localparam logic [QF_W-1:0] Q_POS_ONE = 10'h1FF;
  localparam logic [QF_W-1:0] Q_NEG_ONE = 10'h201;
  localparam logic [QF_W-1:0] Q_ZERO    = 10'h000;

  // unpacked float: flags plus normalised significand, exponent unbounded
  typedef struct packed {
    logic                    nan;
    logic                    inf;
    logic                    zero;
    logic                    sgn;
    logic signed [EXP_W-1:0] ex;
    logic [MAN_W-1:0]        man;
  } fnum_t;

  typedef struct packed {
    logic        last;
    logic [31:0] len_word;
    fnum_t       len;
    fnum_t [2:0] pos;
    fnum_t [5:0] nt;
  } side_t;

  function automatic logic is_nan(input logic [31:0] x);
    return (&x[30:23]) & (|x[22:0]);
  endfunction

  function automatic logic [MAN_W-1:0] sig_of(input logic [31:0] x);
    return {|x[30:23], x[22:0]};
  endfunction

  function automatic logic [LZ_W-1:0] lzc(input logic [MAN_W-1:0] m);
    logic [LZ_W-1:0] n;
    n = '0;
    for (int i = 0; i < MAN_W; i++) begin
      if (m[i]) n = LZ_W'(MAN_W - 1 - i);
    end
    return n;
  endfunction

  function automatic fnum_t unpack_norm(input logic [31:0] x, input logic [LZ_W-1:0] lz);
    fnum_t f;
    logic [7:0] e;
    logic [MAN_W-1:0] m;
    e      = x[30:23];
    m      = sig_of(x);
    f.nan  = is_nan(x);
    f.inf  = (&e) & ~(|x[22:0]);
    f.zero = ~(|m);
    f.sgn  = x[31];
    f.ex   = (e == 8'd0) ? (EXP_W'(1) - EXP_W'(lz)) : (EXP_W'(e) - EXP_W'(lz));
    f.man  = m << lz;
    return f;
  endfunction

  // subnormals quantise to zero anyway, so no normalisation here
  function automatic fnum_t unpack_flush(input logic [31:0] x);
    fnum_t f;
    f      = unpack_norm(x, '0);
    f.zero = (x[30:23] == 8'd0);
    return f;
  endfunction

endpackage

FILE: hw/rtl/snp_recip.sv
// Pipelined correctly rounded single-precision reciprocal with a sideband carried alongside.
module snp_recip (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  snp_pkg::side_t  in_side,
  output logic            out_vld,
  output snp_pkg::side_t  out_side,
  output snp_pkg::fnum_t  out_rcp
);

  localparam int N  = snp_pkg::DIV_STAGES;
  localparam int MW = snp_pkg::MAN_W;

  logic              vld_r  [N];
  logic [MW-1:0]     rem_r  [N];
  logic [N-1:0]      quo_r  [N];
  snp_pkg::side_t    side_r [N];
  logic [MW-1:0]     rem_nxt [N];
  logic [N-1:0]      quo_nxt [N];

  logic              out_vld_r;
  snp_pkg::side_t    out_side_r;
  snp_pkg::fnum_t    rcp_r;
  snp_pkg::fnum_t    rcp_nxt;

  // one quotient bit: {bit, new remainder}
  function automatic logic [MW:0] div_step(input logic [MW-1:0] r, input logic [MW-1:0] m);
    logic [MW:0] t;
    logic ge;
    t  = {r, 1'b0};
    ge = (t >= {1'b0, m});
    return {ge, ge ? MW'(t - {1'b0, m}) : t[MW-1:0]};
  endfunction

  always_comb begin
    logic [MW:0] st;
    st         = div_step(MW'(1) << (MW - 2), in_side.len.man);
    rem_nxt[0] = st[MW-1:0];
    quo_nxt[0] = {{(N-1){1'b0}}, st[MW]};
    for (int k = 1; k < N; k++) begin
      st         = div_step(rem_r[k-1], side_r[k-1].len.man);
      rem_nxt[k] = st[MW-1:0];
      quo_nxt[k] = {quo_r[k-1][N-2:0], st[MW]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) vld_r[k] <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
      for (int k = 1; k < N; k++) vld_r[k] <= vld_r[k-1];
      out_vld_r <= vld_r[N-1];
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= in_side;
    for (int k = 1; k < N; k++) side_r[k] <= side_r[k-1];
    for (int k = 0; k < N; k++) begin
      rem_r[k] <= rem_nxt[k];
      quo_r[k] <= quo_nxt[k];
    end
    out_side_r <= side_r[N-1];
    rcp_r      <= rcp_nxt;
  end

  // rounding, with the subnormal result range folded back to normalised form
  always_comb begin
    logic [N-1:0] q;
    logic stk;
    logic signed [snp_pkg::EXP_W-1:0] el, er, base, ex;
    logic [1:0] sh;
    logic [MW:0] y, rnd;
    logic [MW-1:0] kept, man;
    logic guard;
    q     = quo_r[N-1];
    stk   = |rem_r[N-1];
    el    = side_r[N-1].len.ex;
    er    = 2 * snp_pkg::EXP_BIAS - 10'sd1 - el;
    sh    = (er >= 10'sd1) ? 2'd0 : ((er == 10'sd0) ? 2'd1 : 2'd2);
    y     = q[MW:0] >> sh;
    kept  = y[MW:1];
    guard = y[0];
    stk   = stk | ((sh != 2'd0) & q[0]) | ((sh == 2'd2) & q[1]);
    rnd   = {1'b0, kept} + (MW+1)'(guard & (stk | kept[0]));
    base  = (er >= 10'sd1) ? er : 10'sd1;
    if (q[N-1]) begin
      // significand of one: exact power of two
      man = MW'(1) << (MW - 1);
      ex  = 2 * snp_pkg::EXP_BIAS - el;
    end else if (rnd[MW]) begin
      man = rnd[MW:1];
      ex  = base + 10'sd1;
    end else if (rnd[MW-1]) begin
      man = rnd[MW-1:0];
      ex  = base;
    end else if (rnd[MW-2]) begin
      man = {rnd[MW-2:0], 1'b0};
      ex  = base - 10'sd1;
    end else begin
      man = {rnd[MW-3:0], 2'b00};
      ex  = base - 10'sd2;
    end
    rcp_nxt.nan  = side_r[N-1].len.nan;
    rcp_nxt.zero = side_r[N-1].len.inf;
    rcp_nxt.inf  = ~side_r[N-1].len.nan & ~side_r[N-1].len.inf & (ex >= snp_pkg::EXP_MAX);
    rcp_nxt.sgn  = 1'b0;
    rcp_nxt.ex   = ex;
    rcp_nxt.man  = man;
  end

  assign out_vld  = out_vld_r;
  assign out_side = out_side_r;
  assign out_rcp  = rcp_r;

endmodule

FILE: hw/rtl/snp_fmul.sv
// Two-stage float multiply lane, round to nearest even, unbounded exponent.
module snp_fmul (
  input  logic           clk,
  input  snp_pkg::fnum_t a,
  input  snp_pkg::fnum_t b,
  output snp_pkg::fnum_t y
);

  localparam int MW = snp_pkg::MAN_W;

  logic [2*MW-1:0]                  prod_r;
  logic signed [snp_pkg::EXP_W-1:0] exs_r;
  logic                             nan_r, inf_r, zero_r, sgn_r;
  snp_pkg::fnum_t                   y_r;
  snp_pkg::fnum_t                   y_nxt;
  logic                             nan_nxt;

  assign nan_nxt = a.nan | b.nan | (a.zero & b.inf) | (a.inf & b.zero);

  always_ff @(posedge clk) begin
    prod_r <= (2*MW)'(a.man) * (2*MW)'(b.man);
    exs_r  <= a.ex + b.ex - snp_pkg::EXP_BIAS;
    nan_r  <= nan_nxt;
    inf_r  <= ~nan_nxt & (a.inf | b.inf);
    zero_r <= ~nan_nxt & (a.zero | b.zero);
    sgn_r  <= a.sgn ^ b.sgn;
    y_r    <= y_nxt;
  end

  always_comb begin
    logic hi, g, st;
    logic [MW-1:0] mant;
    logic [MW:0] rnd;
    hi   = prod_r[2*MW-1];
    mant = hi ? prod_r[2*MW-1:MW] : prod_r[2*MW-2:MW-1];
    g    = hi ? prod_r[MW-1] : prod_r[MW-2];
    st   = hi ? (|prod_r[MW-2:0]) : (|prod_r[MW-3:0]);
    rnd  = {1'b0, mant} + (MW+1)'(g & (st | mant[0]));
    y_nxt.nan  = nan_r;
    y_nxt.inf  = inf_r;
    y_nxt.zero = zero_r;
    y_nxt.sgn  = sgn_r;
    y_nxt.man  = rnd[MW] ? rnd[MW:1] : rnd[MW-1:0];
    y_nxt.ex   = exs_r + snp_pkg::EXP_W'(hi) + snp_pkg::EXP_W'(rnd[MW]);
  end

  assign y = y_r;

endmodule

FILE: hw/rtl/snp_quant.sv
// Three-stage quantiser lane: clamp to unit range, scale by 511 in single precision, round to int.
module snp_quant (
  input  logic                     clk,
  input  snp_pkg::fnum_t           v,
  output logic [snp_pkg::QF_W-1:0] q
);

  localparam int MW = snp_pkg::MAN_W;
  localparam int PW = MW + 9;
  localparam int SCALE = 511;
  // s = kr * 2^(ex - SHIFT_BASE + top)
  localparam int SHIFT_BASE = 127 + (MW - 1) - (PW - MW - 1);
  // below 2^-11 the scaled value cannot reach one half
  localparam int EX_SMALL = 127 - 11;

  logic                             spec_a_r, spec_b_r, spec_c;
  logic [snp_pkg::QF_W-1:0]         code_a_r, code_b_r, code_nxt;
  logic                             sgn_a_r, sgn_b_r;
  logic signed [snp_pkg::EXP_W-1:0] ex_a_r;
  logic [PW-1:0]                    prod_a_r;
  logic [MW:0]                      kr_b_r, kr_nxt;
  logic [4:0]                       n_b_r, n_nxt;
  logic [snp_pkg::QF_W-1:0]         q_r, q_nxt;

  always_comb begin
    spec_c   = 1'b1;
    code_nxt = snp_pkg::Q_ZERO;
    if (v.nan) begin
      code_nxt = snp_pkg::Q_NEG_ONE;
    end else if (v.zero) begin
      code_nxt = snp_pkg::Q_ZERO;
    end else if (v.inf || v.ex >= snp_pkg::EXP_BIAS) begin
      code_nxt = v.sgn ? snp_pkg::Q_NEG_ONE : snp_pkg::Q_POS_ONE;
    end else if (v.ex < snp_pkg::EXP_W'(EX_SMALL)) begin
      code_nxt = snp_pkg::Q_ZERO;
    end else begin
      spec_c = 1'b0;
    end
  end

  always_comb begin
    logic top, g, st;
    logic [MW-1:0] kept;
    logic signed [snp_pkg::EXP_W-1:0] nf;
    top    = prod_a_r[PW-1];
    kept   = top ? prod_a_r[PW-1:PW-MW] : prod_a_r[PW-2:PW-MW-1];
    g      = top ? prod_a_r[PW-MW-1] : prod_a_r[PW-MW-2];
    st     = top ? (|prod_a_r[PW-MW-2:0]) : (|prod_a_r[PW-MW-3:0]);
    kr_nxt = {1'b0, kept} + (MW+1)'(g & (st | kept[0]));
    nf     = snp_pkg::EXP_W'(SHIFT_BASE) - ex_a_r - snp_pkg::EXP_W'(top);
    n_nxt  = nf[4:0];
  end

  always_comb begin
    logic [MW:0] sm1, mask;
    logic [snp_pkg::QF_W-1:0] ip, mag;
    logic half, stick;
    sm1   = kr_b_r >> (n_b_r - 5'd1);
    mask  = ((MW+1)'(1) << (n_b_r - 5'd1)) - (MW+1)'(1);
    half  = sm1[0];
    ip    = sm1[snp_pkg::QF_W:1];
    stick = |(kr_b_r & mask);
    mag   = ip + snp_pkg::QF_W'(half & (stick | ip[0]));
    q_nxt = spec_b_r ? code_b_r : (sgn_b_r ? (~mag + snp_pkg::QF_W'(1)) : mag);
  end

  always_ff @(posedge clk) begin
    spec_a_r <= spec_c;
    code_a_r <= code_nxt;
    sgn_a_r  <= v.sgn;
    ex_a_r   <= v.ex;
    prod_a_r <= PW'(v.man) * PW'(SCALE);
    spec_b_r <= spec_a_r;
    code_b_r <= code_a_r;
    sgn_b_r  <= sgn_a_r;
    kr_b_r   <= kr_nxt;
    n_b_r    <= n_nxt;
    q_r      <= q_nxt;
  end

  assign q = q_r;

endmodule

FILE: hw/rtl/vertex_offset_snorm10_packer_unit.sv
// Top level of the SNORM 10:10:10 vertex offset packer.
// One vertex is taken in every cycle (busy is low except in reset) and its four words
// leave together on out_valid, in the order taken; the receiver cannot stall, so
// results must be captured on the strobe. The latency is set by the reciprocal of the
// length, a restoring divider of one quotient bit per stage (26 stages); the three
// position multiplies and nine quantiser lanes follow it and a final stage packs.
module vertex_offset_snorm10_packer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_position_x,
  input  logic [31:0] in_position_y,
  input  logic [31:0] in_position_z,
  input  logic [31:0] in_normal_x,
  input  logic [31:0] in_normal_y,
  input  logic [31:0] in_normal_z,
  input  logic [31:0] in_tangent_x,
  input  logic [31:0] in_tangent_y,
  input  logic [31:0] in_tangent_z,
  input  logic        in_last_in,
  output logic        out_valid,
  output logic [31:0] out_length_word,
  output logic [29:0] out_position_word,
  output logic [29:0] out_normal_word,
  output logic [29:0] out_tangent_word,
  output logic        out_last_out
);

  localparam int QW = snp_pkg::QF_W;

  logic accept;
  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  logic        s0_vld_r, s1_vld_r, s2_vld_r, s3_vld_r;
  logic [31:0] s0_w_r [9];
  logic [31:0] s1_w_r [9];
  logic [31:0] s2_w_r [9];
  logic        s0_last_r, s1_last_r, s2_last_r;
  logic [31:0] s1_len_r, s2_len_r, len_nxt;
  logic [snp_pkg::LZ_W-1:0] s2_lz_r [4];
  snp_pkg::side_t s3_side_r, side_nxt;

  // length: largest magnitude; a NaN in x or y yields the next operand, a NaN in z wins
  always_comb begin
    logic [30:0] a0, a1, a2, m1, lmax;
    logic n0, n1, n2, gt_ab, gt_mc;
    a0    = s0_w_r[0][30:0];
    a1    = s0_w_r[1][30:0];
    a2    = s0_w_r[2][30:0];
    n0    = snp_pkg::is_nan({1'b0, a0});
    n1    = snp_pkg::is_nan({1'b0, a1});
    n2    = snp_pkg::is_nan({1'b0, a2});
    gt_ab = ~n0 & ~n1 & (a0 > a1);
    m1    = gt_ab ? a0 : a1;
    gt_mc = gt_ab ? (~n0 & ~n2 & (a0 > a2)) : (~n1 & ~n2 & (a1 > a2));
    lmax  = gt_mc ? m1 : a2;
    len_nxt = (lmax == 31'd0) ? snp_pkg::ONE_BITS : {1'b0, lmax};
  end

  always_comb begin
    side_nxt.last     = s2_last_r;
    side_nxt.len_word = s2_len_r;
    side_nxt.len      = snp_pkg::unpack_norm(s2_len_r, s2_lz_r[0]);
    for (int k = 0; k < 3; k++) begin
      side_nxt.pos[k] = snp_pkg::unpack_norm(s2_w_r[k], s2_lz_r[k+1]);
    end
    for (int k = 0; k < 6; k++) begin
      side_nxt.nt[k] = snp_pkg::unpack_flush(s2_w_r[k+3]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= accept;
      s1_vld_r <= s0_vld_r;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s0_w_r[0] <= in_position_x;
    s0_w_r[1] <= in_position_y;
    s0_w_r[2] <= in_position_z;
    s0_w_r[3] <= in_normal_x;
    s0_w_r[4] <= in_normal_y;
    s0_w_r[5] <= in_normal_z;
    s0_w_r[6] <= in_tangent_x;
    s0_w_r[7] <= in_tangent_y;
    s0_w_r[8] <= in_tangent_z;
    s0_last_r <= in_last_in;
    s1_w_r    <= s0_w_r;
    s1_last_r <= s0_last_r;
    s1_len_r  <= len_nxt;
    s2_w_r    <= s1_w_r;
    s2_last_r <= s1_last_r;
    s2_len_r  <= s1_len_r;
    s2_lz_r[0] <= snp_pkg::lzc(snp_pkg::sig_of(s1_len_r));
    for (int k = 0; k < 3; k++) begin
      s2_lz_r[k+1] <= snp_pkg::lzc(snp_pkg::sig_of(s1_w_r[k]));
    end
    s3_side_r <= side_nxt;
  end

  logic           rc_vld;
  snp_pkg::side_t rc_side;
  snp_pkg::fnum_t rc_rcp;

  snp_recip u_recip (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s3_vld_r),
    .in_side  (s3_side_r),
    .out_vld  (rc_vld),
    .out_side (rc_side),
    .out_rcp  (rc_rcp)
  );

  snp_pkg::fnum_t pprod [3];

  for (genvar k = 0; k < 3; k++) begin : g_mul
    snp_fmul u_fmul (
      .clk (clk),
      .a   (rc_side.pos[k]),
      .b   (rc_rcp),
      .y   (pprod[k])
    );
  end

  // sideband alongside the multiply lanes
  logic           m_vld_r  [snp_pkg::LAT_MUL];
  logic           m_last_r [snp_pkg::LAT_MUL];
  logic [31:0]    m_len_r  [snp_pkg::LAT_MUL];
  snp_pkg::fnum_t [5:0] m_nt_r [snp_pkg::LAT_MUL];
  // and alongside the quantisers
  logic           q_vld_r  [snp_pkg::LAT_QUANT];
  logic           q_last_r [snp_pkg::LAT_QUANT];
  logic [31:0]    q_len_r  [snp_pkg::LAT_QUANT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < snp_pkg::LAT_MUL; k++) m_vld_r[k] <= 1'b0;
      for (int k = 0; k < snp_pkg::LAT_QUANT; k++) q_vld_r[k] <= 1'b0;
    end else begin
      m_vld_r[0] <= rc_vld;
      for (int k = 1; k < snp_pkg::LAT_MUL; k++) m_vld_r[k] <= m_vld_r[k-1];
      q_vld_r[0] <= m_vld_r[snp_pkg::LAT_MUL-1];
      for (int k = 1; k < snp_pkg::LAT_QUANT; k++) q_vld_r[k] <= q_vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    m_last_r[0] <= rc_side.last;
    m_len_r[0]  <= rc_side.len_word;
    m_nt_r[0]   <= rc_side.nt;
    for (int k = 1; k < snp_pkg::LAT_MUL; k++) begin
      m_last_r[k] <= m_last_r[k-1];
      m_len_r[k]  <= m_len_r[k-1];
      m_nt_r[k]   <= m_nt_r[k-1];
    end
    q_last_r[0] <= m_last_r[snp_pkg::LAT_MUL-1];
    q_len_r[0]  <= m_len_r[snp_pkg::LAT_MUL-1];
    for (int k = 1; k < snp_pkg::LAT_QUANT; k++) begin
      q_last_r[k] <= q_last_r[k-1];
      q_len_r[k]  <= q_len_r[k-1];
    end
  end

  snp_pkg::fnum_t qin [9];
  logic [QW-1:0]  qf  [9];

  always_comb begin
    for (int k = 0; k < 3; k++) qin[k] = pprod[k];
    for (int k = 0; k < 6; k++) qin[k+3] = m_nt_r[snp_pkg::LAT_MUL-1][k];
  end

  for (genvar k = 0; k < 9; k++) begin : g_quant
    snp_quant u_quant (
      .clk (clk),
      .v   (qin[k]),
      .q   (qf[k])
    );
  end

  // merge the lanes into the output beat
  logic        out_valid_r;
  logic        out_last_r;
  logic [31:0] out_len_r;
  logic [29:0] out_pos_r, out_nrm_r, out_tan_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= q_vld_r[snp_pkg::LAT_QUANT-1];
    end
  end

  always_ff @(posedge clk) begin
    out_last_r <= q_last_r[snp_pkg::LAT_QUANT-1];
    out_len_r  <= q_len_r[snp_pkg::LAT_QUANT-1];
    out_pos_r  <= {qf[2], qf[1], qf[0]};
    out_nrm_r  <= {qf[5], qf[4], qf[3]};
    out_tan_r  <= {qf[8], qf[7], qf[6]};
  end

  assign out_valid         = out_valid_r;
  assign out_last_out      = out_last_r;
  assign out_length_word   = out_len_r;
  assign out_position_word = out_pos_r;
  assign out_normal_word   = out_nrm_r;
  assign out_tangent_word  = out_tan_r;

  // a length is a magnitude and never zero
  a_len_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_length_word[31] && out_length_word != 32'd0))
    else $error("length word negative or zero");

  // every beat out comes from a start beat a fixed latency earlier
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, snp_pkg::LAT_TOTAL))
    else $error("result beat without matching start beat");

  a_rcp_src: assert property (@(posedge clk) disable iff (!rst_n)
    rc_vld |-> $past(s3_vld_r, snp_pkg::LAT_RCP))
    else $error("reciprocal pipeline valid out of step");

  // a NaN length means a NaN reciprocal, so every position field clamps low
  a_nan_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (&out_length_word[30:23]) && (|out_length_word[22:0])) |->
      (out_position_word == {snp_pkg::Q_NEG_ONE, snp_pkg::Q_NEG_ONE, snp_pkg::Q_NEG_ONE}))
    else $error("NaN length with non-saturated position");

endmodule

FILE: dv/vertex_offset_snorm10_packer_unit_tb.sv
// Self-checking testbench for the SNORM 10:10:10 vertex offset packer.
`timescale 1ns / 100ps

module vertex_offset_snorm10_packer_unit_tb;

  localparam int N_ITEMS   = 550;
  localparam int N_DIRECT  = 12;
  localparam int WDOG_MAX  = 4000;
  localparam logic [31:0] F_ONE  = 32'h3F80_0000;
  localparam logic [31:0] F_MONE = 32'hBF80_0000;
  localparam logic [31:0] F_TWO  = 32'h4000_0000;
  localparam logic [31:0] F_MTWO = 32'hC000_0000;
  localparam logic [31:0] F_HALF = 32'h3F00_0000;
  localparam logic [31:0] F_MHALF = 32'hBF00_0000;
  localparam logic [31:0] F_INF  = 32'h7F80_0000;
  localparam logic [31:0] F_MINF = 32'hFF80_0000;
  localparam logic [31:0] F_NAN  = 32'h7FC0_0000;
  localparam logic [31:0] F_MZERO = 32'h8000_0000;
  localparam logic [31:0] F_FMAX = 32'h7F7F_FFFF;
  localparam logic [31:0] F_TINY = 32'h0000_0001;

  typedef struct packed {
    logic [8:0][31:0] w;   // px py pz nx ny nz tx ty tz
    logic             last;
  } vertex_t;

  typedef struct packed {
    logic [31:0] len;
    logic [29:0] pos;
    logic [29:0] nrm;
    logic [29:0] tan;
    logic        last;
  } packed_vtx_t;

  typedef struct {
    vertex_t     v;
    bit          typed;
    packed_vtx_t e;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [31:0] in_position_x = '0, in_position_y = '0, in_position_z = '0;
  logic [31:0] in_normal_x = '0, in_normal_y = '0, in_normal_z = '0;
  logic [31:0] in_tangent_x = '0, in_tangent_y = '0, in_tangent_z = '0;
  logic in_last_in = 1'b0;
  logic out_valid;
  logic [31:0] out_length_word;
  logic [29:0] out_position_word, out_normal_word, out_tangent_word;
  logic out_last_out;

  vertex_offset_snorm10_packer_unit dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  packed_vtx_t expected_q[$];
  stim_row_t   stim_table[N_DIRECT];
  vertex_t     cur_vtx;
  bit          cur_typed;
  packed_vtx_t cur_exp;
  int          n_errors = 0;
  int          idle_cycles = 0;

  // single float bits to an exact double
  function automatic real f2d(input logic [31:0] b);
    logic [63:0] d;
    logic [23:0] m;
    int k;
    if (b[30:23] == 8'hFF) d = {b[31], 11'h7FF, b[22:0], 29'b0};
    else if (b[30:0] == '0) d = {b[31], 63'b0};
    else if (b[30:23] == 8'h00) begin
      m = {1'b0, b[22:0]};
      k = 0;
      while (!m[23]) begin
        m = m << 1;
        k++;
      end
      d = {b[31], 11'(1023 - 126 - k), m[22:0], 29'b0};
    end else d = {b[31], 11'(int'(b[30:23]) - 127 + 1023), b[22:0], 29'b0};
    return $bitstoreal(d);
  endfunction

  // double to single, round to nearest even, subnormals kept
  function automatic logic [31:0] d2f(input real r);
    logic [63:0] d, sig, q, rem, half;
    int u, sh;
    d = $realtobits(r);
    if (d[62:52] == 11'h7FF) return (d[51:0] != '0) ? F_NAN : {d[63], 31'h7F80_0000};
    if (d[62:52] == 11'h000) return {d[63], 31'b0};
    u = int'(d[62:52]) - 1023;
    if (u > 127) return {d[63], 31'h7F80_0000};
    sig = {11'b0, 1'b1, d[51:0]};
    sh = (u >= -126) ? 29 : 29 + (-126 - u);
    if (sh > 54) return {d[63], 31'b0};
    q = sig >> sh;
    rem = sig & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 1;
    if (u >= -126) begin
      if (q[24]) begin
        q = q >> 1;
        u++;
      end
      if (u > 127) return {d[63], 31'h7F80_0000};
      return {d[63], 8'(u + 127), q[22:0]};
    end
    return {d[63], q[30:0]};   // carry into the exponent falls out naturally
  endfunction

  function automatic logic [9:0] quantise(input real v);
    real c, s, rr;
    int t;
    c = (v > -1.0) ? v : -1.0;
    c = (c < 1.0) ? c : 1.0;
    s = f2d(d2f(c * 511.0));
    t = $rtoi(s);
    rr = s - t;
    if (rr > 0.5) t = t + 1;
    else if (rr < -0.5) t = t - 1;
    else if (rr == 0.5) t = t + (t & 1);
    else if (rr == -0.5) t = t - (t & 1);
    return t[9:0];
  endfunction

  function automatic logic [29:0] pack_xyz(input real x, input real y, input real z);
    return {quantise(z), quantise(y), quantise(x)};
  endfunction

  function automatic packed_vtx_t predict_vertex(input vertex_t v);
    packed_vtx_t p;
    logic [31:0] m, a;
    real len, rcp;
    real c[9];
    for (int i = 0; i < 9; i++) c[i] = f2d(v.w[i]);
    m = {1'b0, v.w[0][30:0]};
    for (int i = 1; i < 3; i++) begin
      a = {1'b0, v.w[i][30:0]};
      m = (f2d(m) > f2d(a)) ? m : a;
    end
    len = f2d(m);
    if (len == 0.0) begin
      m = F_ONE;
      rcp = 1.0;
    end else rcp = f2d(d2f(1.0 / len));
    p.len  = m;
    p.pos  = pack_xyz(f2d(d2f(c[0] * rcp)), f2d(d2f(c[1] * rcp)), f2d(d2f(c[2] * rcp)));
    p.nrm  = pack_xyz(c[3], c[4], c[5]);
    p.tan  = pack_xyz(c[6], c[7], c[8]);
    p.last = v.last;
    return p;
  endfunction

  function automatic logic [31:0] rand_float();
    case ($urandom_range(9))
      0, 1: return $urandom;
      2: return {1'($urandom_range(1)), 31'b0};
      3: return {1'($urandom_range(1)), 8'hFF, ($urandom_range(1) ? 23'($urandom) : 23'b0)};
      4: return {1'($urandom_range(1)), 8'h00, 23'($urandom)};
      default: return {1'($urandom_range(1)), 8'($urandom_range(110, 128)), 23'($urandom)};
    endcase
  endfunction

  function automatic stim_row_t mk_row(input logic [31:0] p0, p1, p2, n0, n1, n2,
                                       t0, t1, t2, input logic lst, input bit typed,
                                       input packed_vtx_t e);
    stim_row_t r;
    r.v.w = {t2, t1, t0, n2, n1, n0, p2, p1, p0};
    r.v.last = lst;
    r.typed = typed;
    r.e = e;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    n_errors++;
  endtask

  initial begin
    stim_table[0]  = mk_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
                            '{F_ONE, 30'h0, 30'h0, 30'h0, 1'b0});
    stim_table[1]  = mk_row(F_ONE, 0, 0, F_ONE, F_ONE, F_ONE, F_MONE, F_MONE, F_MONE, 1, 1,
                            '{F_ONE, 30'h1FF, 30'h1FF7FDFF, 30'h20180601, 1'b1});
    stim_table[2]  = mk_row(F_MTWO, 0, 0, F_NAN, F_NAN, F_NAN, F_TWO, F_TWO, F_TWO, 0, 1,
                            '{F_TWO, 30'h201, 30'h20180601, 30'h1FF7FDFF, 1'b0});
    // negative zero length, half-way ties
    stim_table[3]  = mk_row(F_MZERO, F_MZERO, 0, F_HALF, F_MHALF, F_MZERO, F_HALF, F_MHALF,
                            0, 1, 0, '0);
    stim_table[4]  = mk_row(F_INF, F_ONE, F_MONE, F_INF, F_MINF, F_FMAX, 0, 0, 0, 0, 0, '0);
    stim_table[5]  = mk_row(F_NAN, F_ONE, F_TWO, F_TINY, 32'h807F_FFFF, 0, 0, 0, 0, 0, 0, '0);
    stim_table[6]  = mk_row(F_ONE, F_NAN, F_HALF, 0, 0, 0, F_TINY, 0, 0, 1, 0, '0);
    stim_table[7]  = mk_row(F_TINY, 32'h8000_0002, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0);
    stim_table[8]  = mk_row(F_FMAX, 32'hFF7F_FFFF, F_TINY, 0, 0, 0, 0, 0, 0, 1, 0, '0);
    stim_table[9]  = mk_row(F_MINF, F_MINF, F_INF, 0, 0, 0, 0, 0, 0, 0, 0, '0);
    stim_table[10] = mk_row('1, '1, '1, '1, '1, '1, '1, '1, '1, 1, 0, '0);
    stim_table[11] = mk_row(32'h3EAA_AAAB, 32'hBF40_0000, 32'h3DCC_CCCD, 32'h3F7F_FFFF,
                            32'hBF7F_FFFF, 32'h3A80_0000, 32'h3F00_0001, 32'hBEFF_FFFF,
                            32'h3C00_0000, 0, 0, '0);
  end

  // stimulus: one vertex presented per step, held until taken
  initial begin
    int n;
    bit quiet;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    n = 0;
    while (n < N_ITEMS) begin
      @(posedge clk);
      if (start && !busy) begin
        expected_q.push_back(cur_typed ? cur_exp : predict_vertex(cur_vtx));
        n++;
      end
      if (start && !busy || !start) begin
        quiet = (n >= 200 && n < 330);
        if (n < N_ITEMS && (quiet || $urandom_range(99) >= 10)) begin
          if (n < N_DIRECT) begin
            cur_vtx   = stim_table[n].v;
            cur_typed = stim_table[n].typed;
            cur_exp   = stim_table[n].e;
          end else begin
            for (int i = 0; i < 9; i++) cur_vtx.w[i] = rand_float();
            cur_vtx.last = ($urandom_range(7) == 0);
            cur_typed = 0;
          end
          in_position_x <= cur_vtx.w[0];
          in_position_y <= cur_vtx.w[1];
          in_position_z <= cur_vtx.w[2];
          in_normal_x   <= cur_vtx.w[3];
          in_normal_y   <= cur_vtx.w[4];
          in_normal_z   <= cur_vtx.w[5];
          in_tangent_x  <= cur_vtx.w[6];
          in_tangent_y  <= cur_vtx.w[7];
          in_tangent_z  <= cur_vtx.w[8];
          in_last_in    <= cur_vtx.last;
          start <= 1'b1;
        end else start <= 1'b0;
      end
    end
    while (expected_q.size() != 0) @(posedge clk);
    repeat (snp_pkg::LAT_TOTAL + 20) @(posedge clk);
    if (n_errors == 0) $display("[vertex_offset_snorm10_packer_unit] OK");
    else $display("[vertex_offset_snorm10_packer_unit] ERROR");
    $finish;
  end

  // result beats are compared against the oldest pending vertex
  always @(posedge clk) begin
    packed_vtx_t e;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) report_mismatch("unexpected beat", out_length_word, 0);
      else begin
        e = expected_q.pop_front();
        if (out_length_word !== e.len) report_mismatch("length", out_length_word, e.len);
        if (out_position_word !== e.pos)
          report_mismatch("position", {2'b0, out_position_word}, {2'b0, e.pos});
        if (out_normal_word !== e.nrm)
          report_mismatch("normal", {2'b0, out_normal_word}, {2'b0, e.nrm});
        if (out_tangent_word !== e.tan)
          report_mismatch("tangent", {2'b0, out_tangent_word}, {2'b0, e.tan});
        if (out_last_out !== e.last)
          report_mismatch("last", {31'b0, out_last_out}, {31'b0, e.last});
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("[vertex_offset_snorm10_packer_unit] ERROR");
      $finish;
    end
  end

endmodule

FILE: files.f
hw/rtl/snp_pkg.sv
hw/rtl/snp_recip.sv
hw/rtl/snp_fmul.sv
hw/rtl/snp_quant.sv
hw/rtl/vertex_offset_snorm10_packer_unit.sv
dv/vertex_offset_snorm10_packer_unit_tb.sv
